/* design/mixed_radix_cell_index_defines.svh */
// ----------------------------------------------------------------------------
// mixed_radix_cell_index_defines.svh
// Assertion macros used by the mixed-radix cell index top level
// ----------------------------------------------------------------------------
`ifndef MIXED_RADIX_CELL_INDEX_DEFINES_SVH
`define MIXED_RADIX_CELL_INDEX_DEFINES_SVH

// same-cycle implication, checked on aclk, off while aresetn is low
`define MRCI_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on aclk, off while aresetn is low
`define MRCI_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/mrci_pkg.sv */
// ----------------------------------------------------------------------------
// mrci_pkg
// Types, widths and codes shared by the mixed-radix cell index pipeline
// ----------------------------------------------------------------------------
package mrci_pkg;

    // field widths
    localparam int CELL_RADIX_W = 7;
    localparam int ATOM_RADIX_W = 13;
    localparam int INDEX_W      = 30;
    localparam int COORD_W      = 6;
    localparam int ATOM_W       = 12;
    localparam int ACC_W        = INDEX_W;
    localparam int TOTAL_W      = 3 * CELL_RADIX_W + ATOM_RADIX_W;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = ATOM_RADIX_W;
    localparam int ERR_W        = 3;

    // divider pipeline shape
    localparam int DIV_STEPS_PER_STAGE = 6;
    localparam int DIV_STAGES = (INDEX_W + DIV_STEPS_PER_STAGE - 1) / DIV_STEPS_PER_STAGE;
    localparam int NUM_DIGITS = 3;
    localparam int NUM_STAGES = 2 + NUM_DIGITS * DIV_STAGES;

    typedef enum logic {
        CMD_DECOMPOSE = 1'b0,
        CMD_COMPOSE   = 1'b1
    } mrci_cmd_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE  = 3'd0,
        ERR_INDEX = 3'd1,
        ERR_A     = 3'd2,
        ERR_B     = 3'd3,
        ERR_C     = 3'd4,
        ERR_ATOM  = 3'd5
    } mrci_err_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_CELLS_A = 2'd0,
        REG_CELLS_B = 2'd1,
        REG_CELLS_C = 2'd2,
        REG_ATOMS   = 2'd3
    } mrci_reg_t;

    // effective radices after zero and saturation handling
    typedef struct packed {
        logic [CELL_RADIX_W-1:0] na;
        logic [CELL_RADIX_W-1:0] nb;
        logic [CELL_RADIX_W-1:0] nc;
        logic [ATOM_RADIX_W-1:0] nt;
    } mrci_radix_t;

    // one input transfer
    typedef struct packed {
        mrci_cmd_t           cmd;
        logic [INDEX_W-1:0]  flat_index;
        logic [COORD_W-1:0]  coord_a;
        logic [COORD_W-1:0]  coord_b;
        logic [COORD_W-1:0]  coord_c;
        logic [ATOM_W-1:0]   atom_number;
    } mrci_in_t;

    // item state carried down the pipeline
    typedef struct packed {
        mrci_cmd_t               cmd;
        logic [INDEX_W-1:0]      idx;
        logic [INDEX_W-1:0]      quo;
        logic [CELL_RADIX_W-1:0] rem;
        logic [COORD_W-1:0]      a;
        logic [COORD_W-1:0]      b;
        logic [COORD_W-1:0]      c;
        logic [ATOM_W-1:0]       atom;
        logic [ACC_W-1:0]        acc;
        logic [TOTAL_W-1:0]      total;
        mrci_err_t               err;
    } mrci_item_t;

    // one result transfer
    typedef struct packed {
        logic [INDEX_W-1:0] out_index;
        logic [COORD_W-1:0] out_a;
        logic [COORD_W-1:0] out_b;
        logic [COORD_W-1:0] out_c;
        logic [ATOM_W-1:0]  out_atom;
        mrci_err_t          error_code;
    } mrci_res_t;

endpackage

/* design/mrci_entry.sv */
// ----------------------------------------------------------------------------
// mrci_entry
// First pipeline stage: coordinate range checks, first compose product and
// first radix product for the total count
// ----------------------------------------------------------------------------
module mrci_entry (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  advance,
    input  logic                  in_valid,
    input  mrci_pkg::mrci_in_t    in_item,
    input  mrci_pkg::mrci_radix_t radix,
    output logic                  out_valid,
    output mrci_pkg::mrci_item_t  out_item
);

    localparam int CW = mrci_pkg::CELL_RADIX_W;
    localparam int TW = mrci_pkg::ATOM_RADIX_W;
    localparam int AW = mrci_pkg::ACC_W;
    localparam int SW = mrci_pkg::TOTAL_W;

    logic                 valid_reg;
    mrci_pkg::mrci_item_t item_reg;
    mrci_pkg::mrci_item_t item_next;

    // range checks in the order a, b, c, atom; seed compose and total products
    always_comb begin
        item_next       = '0;
        item_next.cmd   = in_item.cmd;
        item_next.idx   = in_item.flat_index;
        item_next.quo   = in_item.flat_index;
        item_next.rem   = '0;
        item_next.a     = in_item.coord_a;
        item_next.b     = in_item.coord_b;
        item_next.c     = in_item.coord_c;
        item_next.atom  = in_item.atom_number;
        item_next.acc   = AW'(in_item.coord_c) + AW'(in_item.atom_number) * AW'(radix.nc);
        item_next.total = SW'(radix.na) * SW'(radix.nb);
        item_next.err   = mrci_pkg::ERR_NONE;
        if (in_item.cmd == mrci_pkg::CMD_COMPOSE) begin
            if (CW'(in_item.coord_a) >= radix.na) begin
                item_next.err = mrci_pkg::ERR_A;
            end else if (CW'(in_item.coord_b) >= radix.nb) begin
                item_next.err = mrci_pkg::ERR_B;
            end else if (CW'(in_item.coord_c) >= radix.nc) begin
                item_next.err = mrci_pkg::ERR_C;
            end else if (TW'(in_item.atom_number) >= radix.nt) begin
                item_next.err = mrci_pkg::ERR_ATOM;
            end
        end
    end

    // stage valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
        end
    end

    // stage payload
    always_ff @(posedge aclk) begin
        if (advance) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

/* design/mrci_div_stage.sv */
// ----------------------------------------------------------------------------
// mrci_div_stage
// One divider pipeline stage: STEPS restoring division steps against one
// radix, plus an optional compose / total multiply
// ----------------------------------------------------------------------------
module mrci_div_stage #(
    parameter int DIGIT    = 0,
    parameter int FIRST    = 0,
    parameter int STEPS    = 6,
    parameter int MUL_STEP = 0
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  advance,
    input  logic                  in_valid,
    input  mrci_pkg::mrci_item_t  in_item,
    input  mrci_pkg::mrci_radix_t radix,
    output logic                  out_valid,
    output mrci_pkg::mrci_item_t  out_item
);

    localparam int CW = mrci_pkg::CELL_RADIX_W;
    localparam int IW = mrci_pkg::INDEX_W;
    localparam int XW = mrci_pkg::COORD_W;
    localparam int AW = mrci_pkg::ACC_W;
    localparam int SW = mrci_pkg::TOTAL_W;

    logic                 valid_reg;
    mrci_pkg::mrci_item_t item_reg;
    mrci_pkg::mrci_item_t item_next;
    logic [CW-1:0]        divisor;

    // radix this stage divides by
    generate
        if (DIGIT == 0) begin : g_div_a
            assign divisor = radix.na;
        end else if (DIGIT == 1) begin : g_div_b
            assign divisor = radix.nb;
        end else begin : g_div_c
            assign divisor = radix.nc;
        end
    endgenerate

    // digit handoff, division steps and multiply
    always_comb begin
        logic [CW:0] trial;
        logic        ge;
        item_next = in_item;
        // previous remainder becomes a digit, new division starts from zero
        if (FIRST != 0 && DIGIT > 0) begin
            if (in_item.cmd == mrci_pkg::CMD_DECOMPOSE) begin
                if (DIGIT == 1) begin
                    item_next.a = in_item.rem[XW-1:0];
                end else begin
                    item_next.b = in_item.rem[XW-1:0];
                end
            end
            item_next.rem = '0;
        end
        // restoring division, one quotient bit per step, msb first
        for (int s = 0; s < STEPS; s++) begin
            trial = {item_next.rem, item_next.quo[IW-1]};
            ge    = (trial >= {1'b0, divisor});
            if (ge) begin
                item_next.rem = CW'(trial - {1'b0, divisor});
            end else begin
                item_next.rem = trial[CW-1:0];
            end
            item_next.quo = {item_next.quo[IW-2:0], ge};
        end
        // compose chain and total product
        if (MUL_STEP == 1) begin
            item_next.acc   = AW'(in_item.b) + in_item.acc * AW'(radix.nb);
            item_next.total = in_item.total * SW'(radix.nc);
        end else if (MUL_STEP == 2) begin
            item_next.acc   = AW'(in_item.a) + in_item.acc * AW'(radix.na);
            item_next.total = in_item.total * SW'(radix.nt);
        end
    end

    // stage valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
        end
    end

    // stage payload
    always_ff @(posedge aclk) begin
        if (advance) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

/* design/mrci_result.sv */
// ----------------------------------------------------------------------------
// mrci_result
// Last stage: total check for decompose, result selection, zeroing on error,
// output register
// ----------------------------------------------------------------------------
module mrci_result (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 advance,
    input  logic                 in_valid,
    input  mrci_pkg::mrci_item_t in_item,
    output logic                 out_valid,
    output mrci_pkg::mrci_res_t  out_res
);

    localparam int XW = mrci_pkg::COORD_W;
    localparam int NW = mrci_pkg::ATOM_W;
    localparam int SW = mrci_pkg::TOTAL_W;

    logic                valid_reg;
    mrci_pkg::mrci_res_t res_reg;
    mrci_pkg::mrci_res_t res_next;

    // pick decompose or compose result, zero everything on error
    always_comb begin
        res_next = '0;
        if (in_item.cmd == mrci_pkg::CMD_DECOMPOSE) begin
            res_next.out_index = in_item.idx;
            res_next.out_a     = in_item.a;
            res_next.out_b     = in_item.b;
            res_next.out_c     = in_item.rem[XW-1:0];
            res_next.out_atom  = in_item.quo[NW-1:0];
            if (SW'(in_item.idx) >= in_item.total) begin
                res_next.error_code = mrci_pkg::ERR_INDEX;
            end else begin
                res_next.error_code = mrci_pkg::ERR_NONE;
            end
        end else begin
            res_next.out_index  = in_item.acc;
            res_next.out_a      = in_item.a;
            res_next.out_b      = in_item.b;
            res_next.out_c      = in_item.c;
            res_next.out_atom   = in_item.atom;
            res_next.error_code = in_item.err;
        end
        if (res_next.error_code != mrci_pkg::ERR_NONE) begin
            res_next.out_index = '0;
            res_next.out_a     = '0;
            res_next.out_b     = '0;
            res_next.out_c     = '0;
            res_next.out_atom  = '0;
        end
    end

    // output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
        end
    end

    // output payload
    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

/* design/mixed_radix_cell_index.sv */
// 17 register stages: one entry stage, 15 divider stages of 6 restoring steps
// each, one output stage. Throughput: one item per cycle while the output is not
// stalled; the three chained 30-bit divisions set the depth.
// Stages drain independently, so bubbles close up while the output is stalled.
// Reset: synchronous active-low aresetn clears all stage valids and sets every
// radix register to 1.
// ----------------------------------------------------------------------------
// mixed_radix_cell_index
// Converts a flat supercell index to cell a, b, c and atom coordinates and
// back, with configurable radices and range checking
// ----------------------------------------------------------------------------
`include "mixed_radix_cell_index_defines.svh"

module mixed_radix_cell_index #(
    parameter int MAX_CELLS_PER_AXIS = 64,
    parameter int MAX_ATOMS          = 4096
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // configuration write channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [mrci_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [mrci_pkg::CFG_DATA_W-1:0]      cfg_data,
    // input channel
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_command,
    input  logic [mrci_pkg::INDEX_W-1:0]         s_flat_index,
    input  logic [mrci_pkg::COORD_W-1:0]         s_coord_a,
    input  logic [mrci_pkg::COORD_W-1:0]         s_coord_b,
    input  logic [mrci_pkg::COORD_W-1:0]         s_coord_c,
    input  logic [mrci_pkg::ATOM_W-1:0]          s_atom_number,
    // result channel
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [mrci_pkg::INDEX_W-1:0]         m_out_index,
    output logic [mrci_pkg::COORD_W-1:0]         m_out_a,
    output logic [mrci_pkg::COORD_W-1:0]         m_out_b,
    output logic [mrci_pkg::COORD_W-1:0]         m_out_c,
    output logic [mrci_pkg::ATOM_W-1:0]          m_out_atom,
    output logic [mrci_pkg::ERR_W-1:0]           m_error_code
);

    localparam int CW = mrci_pkg::CELL_RADIX_W;
    localparam int TW = mrci_pkg::ATOM_RADIX_W;
    localparam int NS = mrci_pkg::NUM_STAGES;
    localparam int DS = mrci_pkg::DIV_STAGES;
    localparam int SPS = mrci_pkg::DIV_STEPS_PER_STAGE;
    localparam int IW = mrci_pkg::INDEX_W;

    // saturation limits, clipped to what the radix registers can hold
    localparam int CELL_SAT_I = (MAX_CELLS_PER_AXIS > (1 << CW) - 1) ?
                                (1 << CW) - 1 : MAX_CELLS_PER_AXIS;
    localparam int ATOM_SAT_I = (MAX_ATOMS > (1 << TW) - 1) ? (1 << TW) - 1 : MAX_ATOMS;
    localparam logic [CW-1:0] CELL_SAT = CW'(CELL_SAT_I);
    localparam logic [TW-1:0] ATOM_SAT = TW'(ATOM_SAT_I);

    logic [CW-1:0] cells_a_reg;
    logic [CW-1:0] cells_b_reg;
    logic [CW-1:0] cells_c_reg;
    logic [TW-1:0] atoms_reg;

    mrci_pkg::mrci_radix_t radix;
    mrci_pkg::mrci_in_t    in_item;
    mrci_pkg::mrci_item_t  stage_item [NS-1];
    logic [NS-1:0]         stage_valid;
    logic [NS-1:0]         advance;
    mrci_pkg::mrci_res_t   res;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cells_a_reg <= CW'(1);
            cells_b_reg <= CW'(1);
            cells_c_reg <= CW'(1);
            atoms_reg   <= TW'(1);
        end else if (cfg_valid && cfg_ready) begin
            case (mrci_pkg::mrci_reg_t'(cfg_index))
                mrci_pkg::REG_CELLS_A: begin
                    cells_a_reg <= cfg_data[CW-1:0];
                end
                mrci_pkg::REG_CELLS_B: begin
                    cells_b_reg <= cfg_data[CW-1:0];
                end
                mrci_pkg::REG_CELLS_C: begin
                    cells_c_reg <= cfg_data[CW-1:0];
                end
                mrci_pkg::REG_ATOMS: begin
                    atoms_reg <= cfg_data[TW-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // effective radices: zero reads as one, large values saturate
    assign radix.na = (cells_a_reg == '0) ? CW'(1) :
                      ((cells_a_reg > CELL_SAT) ? CELL_SAT : cells_a_reg);
    assign radix.nb = (cells_b_reg == '0) ? CW'(1) :
                      ((cells_b_reg > CELL_SAT) ? CELL_SAT : cells_b_reg);
    assign radix.nc = (cells_c_reg == '0) ? CW'(1) :
                      ((cells_c_reg > CELL_SAT) ? CELL_SAT : cells_c_reg);
    assign radix.nt = (atoms_reg == '0) ? TW'(1) :
                      ((atoms_reg > ATOM_SAT) ? ATOM_SAT : atoms_reg);

    // input payload
    assign in_item.cmd         = mrci_pkg::mrci_cmd_t'(s_command);
    assign in_item.flat_index  = s_flat_index;
    assign in_item.coord_a     = s_coord_a;
    assign in_item.coord_b     = s_coord_b;
    assign in_item.coord_c     = s_coord_c;
    assign in_item.atom_number = s_atom_number;

    // per-stage advance: a stage loads when it is empty or the next one loads
    assign advance[NS-1] = !stage_valid[NS-1] || m_ready;

    generate
        for (genvar i = 0; i < NS - 1; i++) begin : g_adv
            assign advance[i] = !stage_valid[i] || advance[i+1];
        end
    endgenerate

    assign s_ready = advance[0];

    // entry stage
    mrci_entry u_entry (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance[0]),
        .in_valid  (s_valid),
        .in_item   (in_item),
        .radix     (radix),
        .out_valid (stage_valid[0]),
        .out_item  (stage_item[0])
    );

    // divider stages for radix a, b and c
    generate
        for (genvar k = 1; k < NS - 1; k++) begin : g_div
            localparam int DIG = (k - 1) / DS;
            localparam int POS = (k - 1) % DS;
            localparam int STP = (IW - POS * SPS < SPS) ? IW - POS * SPS : SPS;
            localparam int MUL = (k <= 2) ? k : 0;

            mrci_div_stage #(
                .DIGIT    (DIG),
                .FIRST    ((POS == 0) ? 1 : 0),
                .STEPS    (STP),
                .MUL_STEP (MUL)
            ) u_div (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .advance   (advance[k]),
                .in_valid  (stage_valid[k-1]),
                .in_item   (stage_item[k-1]),
                .radix     (radix),
                .out_valid (stage_valid[k]),
                .out_item  (stage_item[k])
            );
        end
    endgenerate

    // output stage
    mrci_result u_result (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance[NS-1]),
        .in_valid  (stage_valid[NS-2]),
        .in_item   (stage_item[NS-2]),
        .out_valid (stage_valid[NS-1]),
        .out_res   (res)
    );

    assign m_valid      = stage_valid[NS-1];
    assign m_out_index  = res.out_index;
    assign m_out_a      = res.out_a;
    assign m_out_b      = res.out_b;
    assign m_out_c      = res.out_c;
    assign m_out_atom   = res.out_atom;
    assign m_error_code = res.error_code;

    // checks
    `MRCI_ASSERT_IMP(a_err_zeroes_fields, m_valid && (m_error_code != mrci_pkg::ERR_NONE), (m_out_index == '0) && (m_out_a == '0) && (m_out_b == '0) && (m_out_c == '0) && (m_out_atom == '0), "error result carries nonzero fields")
    `MRCI_ASSERT_IMP(a_full_only_when_stalled, !s_ready, m_valid && !m_ready, "input blocked while output not stalled")
    `MRCI_ASSERT_NXT(a_no_phantom_result, !m_valid && !stage_valid[NS-2], !m_valid, "result appeared without an item behind it")

endmodule

/* test/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for mixed_radix_cell_index. Every accepted conversion is
// run through a local predictor of the radix arithmetic and range checks, and
// each returned transfer is compared field by field in order. Directed cases
// cover reset radices, each error code and register zero and saturation
// handling. Random traffic then runs under several radix settings with
// random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CLK_HALF          = 2;
    localparam int RESET_CYCLES      = 12;
    localparam int DRAIN_CYCLES      = 40;
    localparam int STALL_LIMIT       = 4000;
    localparam int CONFIGS_PER_PHASE = 5;
    localparam int ITEMS_PER_CONFIG  = 70;
    localparam int CELL_MAX          = 64;
    localparam int ATOM_MAX          = 4096;
    localparam int IN_RANGE_PCT      = 85;

    // field widths from the package
    localparam int CELL_RADIX_W = mrci_pkg::CELL_RADIX_W;
    localparam int ATOM_RADIX_W = mrci_pkg::ATOM_RADIX_W;
    localparam int INDEX_W      = mrci_pkg::INDEX_W;
    localparam int COORD_W      = mrci_pkg::COORD_W;
    localparam int ATOM_W       = mrci_pkg::ATOM_W;
    localparam int CFG_DATA_W   = mrci_pkg::CFG_DATA_W;
    localparam int ERR_W        = mrci_pkg::ERR_W;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    mrci_pkg::mrci_reg_t    cfg_index = mrci_pkg::REG_CELLS_A;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    logic                   s_command = 1'b0;
    logic [INDEX_W-1:0]     s_flat_index  = '0;
    logic [COORD_W-1:0]     s_coord_a     = '0;
    logic [COORD_W-1:0]     s_coord_b     = '0;
    logic [COORD_W-1:0]     s_coord_c     = '0;
    logic [ATOM_W-1:0]      s_atom_number = '0;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    logic [INDEX_W-1:0]     m_out_index;
    logic [COORD_W-1:0]     m_out_a;
    logic [COORD_W-1:0]     m_out_b;
    logic [COORD_W-1:0]     m_out_c;
    logic [ATOM_W-1:0]      m_out_atom;
    logic [ERR_W-1:0]       m_error_code;

    // local copy of the radix registers, raw as written
    logic [CELL_RADIX_W-1:0] cur_cells_a = 1;
    logic [CELL_RADIX_W-1:0] cur_cells_b = 1;
    logic [CELL_RADIX_W-1:0] cur_cells_c = 1;
    logic [ATOM_RADIX_W-1:0] cur_atoms   = 1;

    int                  tx_idle_pct    = 0;
    int                  rx_idle_pct    = 0;
    int                  mismatch_count = 0;
    mrci_pkg::mrci_res_t pending_results[$];

    always #CLK_HALF aclk = ~aclk;

    mixed_radix_cell_index dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_flat_index  (s_flat_index),
        .s_coord_a     (s_coord_a),
        .s_coord_b     (s_coord_b),
        .s_coord_c     (s_coord_c),
        .s_atom_number (s_atom_number),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_index   (m_out_index),
        .m_out_a       (m_out_a),
        .m_out_b       (m_out_b),
        .m_out_c       (m_out_c),
        .m_out_atom    (m_out_atom),
        .m_error_code  (m_error_code)
    );

    // zero reads as one, anything past the maximum saturates
    function automatic mrci_pkg::mrci_radix_t effective_radices();
        mrci_pkg::mrci_radix_t r;
        r.na = (cur_cells_a == 0) ? CELL_RADIX_W'(1) :
               (cur_cells_a > CELL_MAX) ? CELL_RADIX_W'(CELL_MAX) : cur_cells_a;
        r.nb = (cur_cells_b == 0) ? CELL_RADIX_W'(1) :
               (cur_cells_b > CELL_MAX) ? CELL_RADIX_W'(CELL_MAX) : cur_cells_b;
        r.nc = (cur_cells_c == 0) ? CELL_RADIX_W'(1) :
               (cur_cells_c > CELL_MAX) ? CELL_RADIX_W'(CELL_MAX) : cur_cells_c;
        r.nt = (cur_atoms == 0) ? ATOM_RADIX_W'(1) :
               (cur_atoms > ATOM_MAX) ? ATOM_RADIX_W'(ATOM_MAX) : cur_atoms;
        return r;
    endfunction

    function automatic longint unsigned index_span();
        mrci_pkg::mrci_radix_t r;
        r = effective_radices();
        return longint'(r.na) * r.nb * r.nc * r.nt;
    endfunction

    // expected conversion result under the current radices
    function automatic mrci_pkg::mrci_res_t predict_conversion(mrci_pkg::mrci_in_t item);
        mrci_pkg::mrci_radix_t r;
        longint unsigned       na, nb, nc, nt, q;
        mrci_pkg::mrci_res_t   res;
        r   = effective_radices();
        na  = r.na;
        nb  = r.nb;
        nc  = r.nc;
        nt  = r.nt;
        res = '0;
        res.error_code = mrci_pkg::ERR_NONE;
        if (item.cmd == mrci_pkg::CMD_DECOMPOSE) begin
            q = item.flat_index;
            if (q >= index_span()) begin
                res.error_code = mrci_pkg::ERR_INDEX;
            end else begin
                res.out_index = item.flat_index;
                res.out_a     = COORD_W'(q % na);
                q             = q / na;
                res.out_b     = COORD_W'(q % nb);
                q             = q / nb;
                res.out_c     = COORD_W'(q % nc);
                q             = q / nc;
                res.out_atom  = ATOM_W'(q);
            end
        end else begin
            // coordinates are checked in axis order, atom last
            if (item.coord_a >= na) begin
                res.error_code = mrci_pkg::ERR_A;
            end else if (item.coord_b >= nb) begin
                res.error_code = mrci_pkg::ERR_B;
            end else if (item.coord_c >= nc) begin
                res.error_code = mrci_pkg::ERR_C;
            end else if (item.atom_number >= nt) begin
                res.error_code = mrci_pkg::ERR_ATOM;
            end else begin
                q = longint'(item.atom_number) * nc + item.coord_c;
                q = q * nb + item.coord_b;
                q = q * na + item.coord_a;
                res.out_index = INDEX_W'(q);
                res.out_a     = item.coord_a;
                res.out_b     = item.coord_b;
                res.out_c     = item.coord_c;
                res.out_atom  = item.atom_number;
            end
        end
        return res;
    endfunction

    // decompose request, coordinate fields filled with noise
    function automatic mrci_pkg::mrci_in_t decompose_item(logic [INDEX_W-1:0] idx);
        mrci_pkg::mrci_in_t item;
        item.cmd         = mrci_pkg::CMD_DECOMPOSE;
        item.flat_index  = idx;
        item.coord_a     = COORD_W'($urandom);
        item.coord_b     = COORD_W'($urandom);
        item.coord_c     = COORD_W'($urandom);
        item.atom_number = ATOM_W'($urandom);
        return item;
    endfunction

    // compose request, flat index filled with noise
    function automatic mrci_pkg::mrci_in_t compose_item(
        logic [COORD_W-1:0] a, logic [COORD_W-1:0] b,
        logic [COORD_W-1:0] c, logic [ATOM_W-1:0] t);
        mrci_pkg::mrci_in_t item;
        item.cmd         = mrci_pkg::CMD_COMPOSE;
        item.flat_index  = INDEX_W'($urandom);
        item.coord_a     = a;
        item.coord_b     = b;
        item.coord_c     = c;
        item.atom_number = t;
        return item;
    endfunction

    // mostly inside the radix, sometimes anywhere in the field
    function automatic logic [ATOM_W-1:0] pick_coord(int unsigned n, int width);
        if ($urandom_range(99) < IN_RANGE_PCT)
            return ATOM_W'($urandom_range(n - 1));
        return ATOM_W'($urandom & ((1 << width) - 1));
    endfunction

    function automatic mrci_pkg::mrci_in_t random_item();
        mrci_pkg::mrci_radix_t r;
        longint unsigned       span, edge_idx;
        int                    pick;
        r    = effective_radices();
        span = index_span();
        pick = $urandom_range(9);
        if ($urandom_range(1) == 0) begin
            if (pick < 6)
                return decompose_item(INDEX_W'($urandom_range(32'(span - 1))));
            if (pick < 8) begin
                // just below or at the end of the index space
                edge_idx = span - $urandom_range(1);
                if (edge_idx > {INDEX_W{1'b1}})
                    edge_idx = {INDEX_W{1'b1}};
                return decompose_item(INDEX_W'(edge_idx));
            end
            return decompose_item(INDEX_W'($urandom));
        end
        return compose_item(COORD_W'(pick_coord(r.na, COORD_W)),
                            COORD_W'(pick_coord(r.nb, COORD_W)),
                            COORD_W'(pick_coord(r.nc, COORD_W)),
                            pick_coord(r.nt, ATOM_W));
    endfunction

    // cell radix data, upper bits sometimes set to show they are dropped
    function automatic logic [CFG_DATA_W-1:0] random_cell_radix();
        logic [CFG_DATA_W-1:0] junk;
        int                    pick;
        junk = $urandom_range(1) ? CFG_DATA_W'($urandom_range(63)) << CELL_RADIX_W : '0;
        pick = $urandom_range(99);
        if (pick < 8)
            return junk;
        if (pick < 16)
            return junk | CFG_DATA_W'($urandom_range(127, CELL_MAX + 1));
        if (pick < 28)
            return junk | CFG_DATA_W'(CELL_MAX);
        if (pick < 64)
            return junk | CFG_DATA_W'($urandom_range(6, 1));
        return junk | CFG_DATA_W'($urandom_range(CELL_MAX, 1));
    endfunction

    function automatic logic [CFG_DATA_W-1:0] random_atom_radix();
        int pick;
        pick = $urandom_range(99);
        if (pick < 8)
            return '0;
        if (pick < 16)
            return CFG_DATA_W'($urandom_range(8191, ATOM_MAX + 1));
        if (pick < 28)
            return CFG_DATA_W'(ATOM_MAX);
        if (pick < 64)
            return CFG_DATA_W'($urandom_range(16, 1));
        return CFG_DATA_W'($urandom_range(ATOM_MAX, 1));
    endfunction

    // one input transfer, with random idle cycles ahead of it
    task automatic send_item(input mrci_pkg::mrci_in_t item);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_command     <= item.cmd;
        s_flat_index  <= item.flat_index;
        s_coord_a     <= item.coord_a;
        s_coord_b     <= item.coord_b;
        s_coord_c     <= item.coord_c;
        s_atom_number <= item.atom_number;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        pending_results.push_back(predict_conversion(item));
    endtask

    // register write once the pipeline has drained
    task automatic write_reg(input mrci_pkg::mrci_reg_t sel,
                             input logic [CFG_DATA_W-1:0] data);
        s_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_valid <= 1'b0;
        case (sel)
            mrci_pkg::REG_CELLS_A: cur_cells_a = data[CELL_RADIX_W-1:0];
            mrci_pkg::REG_CELLS_B: cur_cells_b = data[CELL_RADIX_W-1:0];
            mrci_pkg::REG_CELLS_C: cur_cells_c = data[CELL_RADIX_W-1:0];
            mrci_pkg::REG_ATOMS:   cur_atoms   = data[ATOM_RADIX_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_radices(input logic [CFG_DATA_W-1:0] a, input logic [CFG_DATA_W-1:0] b,
                               input logic [CFG_DATA_W-1:0] c, input logic [CFG_DATA_W-1:0] t);
        write_reg(mrci_pkg::REG_CELLS_A, a);
        write_reg(mrci_pkg::REG_CELLS_B, b);
        write_reg(mrci_pkg::REG_CELLS_C, c);
        write_reg(mrci_pkg::REG_ATOMS, t);
    endtask

    // all radices one after reset: only index zero and the origin are valid
    task automatic test_reset_radices();
        send_item(decompose_item('0));
        send_item(decompose_item(INDEX_W'(1)));
        send_item(decompose_item({INDEX_W{1'b1}}));
        send_item(compose_item('0, '0, '0, '0));
        send_item(compose_item({COORD_W{1'b1}}, '0, '0, '0));
        send_item(compose_item('0, '0, '0, {ATOM_W{1'b1}}));
    endtask

    // each error code, the index boundary and check priority
    task automatic test_range_errors();
        set_radices(3, 5, 7, 11);
        send_item(decompose_item(INDEX_W'(1154)));
        send_item(decompose_item(INDEX_W'(1155)));
        send_item(decompose_item(INDEX_W'(777)));
        send_item(compose_item(2, 4, 6, 10));
        send_item(compose_item(3, 0, 0, 0));
        send_item(compose_item(0, 5, 0, 0));
        send_item(compose_item(0, 0, 7, 0));
        send_item(compose_item(0, 0, 0, 11));
        send_item(compose_item({COORD_W{1'b1}}, {COORD_W{1'b1}}, {COORD_W{1'b1}},
                               {ATOM_W{1'b1}}));
        send_item(compose_item(0, {COORD_W{1'b1}}, {COORD_W{1'b1}}, 0));
    endtask

    // saturation above the maximum, zero read as one, exact maximum
    task automatic test_radix_limits();
        set_radices(13'h1fff, 13'h1fff, 13'h1fff, 13'h1fff);
        send_item(decompose_item({INDEX_W{1'b1}}));
        send_item(compose_item({COORD_W{1'b1}}, {COORD_W{1'b1}}, {COORD_W{1'b1}},
                               {ATOM_W{1'b1}}));
        set_radices(0, 0, 0, 0);
        send_item(compose_item('0, '0, '0, '0));
        send_item(compose_item(1, 0, 0, 0));
        send_item(decompose_item('0));
        send_item(decompose_item(INDEX_W'(1)));
        set_radices(CELL_MAX, CELL_MAX, CELL_MAX, ATOM_MAX);
        send_item(decompose_item({INDEX_W{1'b1}}));
        send_item(compose_item('0, '0, '0, {ATOM_W{1'b1}}));
    endtask

    // random conversions under several radix settings
    task automatic test_random_traffic(input int tx_pct, input int rx_pct);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        for (int cfg = 0; cfg < CONFIGS_PER_PHASE; cfg++) begin
            if (cfg == 0)
                set_radices(CELL_MAX, CELL_MAX, CELL_MAX, ATOM_MAX);
            else if (cfg == 1)
                set_radices(1, 1, 1, 1);
            else
                set_radices(random_cell_radix(), random_cell_radix(), random_cell_radix(),
                            random_atom_radix());
            for (int n = 0; n < ITEMS_PER_CONFIG; n++)
                send_item(random_item());
        end
    endtask

    // result channel back-pressure
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    function automatic void check_field(string name, longint unsigned want, logic [63:0] got);
        if (got !== 64'(want)) begin
            $error("%s expected %0d actual %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    // compare each result transfer with the oldest prediction
    always @(posedge aclk) begin
        mrci_pkg::mrci_res_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result transfer, out_index %0d", m_out_index);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("out_index", want.out_index, 64'(m_out_index));
                check_field("out_a", want.out_a, 64'(m_out_a));
                check_field("out_b", want.out_b, 64'(m_out_b));
                check_field("out_c", want.out_c, 64'(m_out_c));
                check_field("out_atom", want.out_atom, 64'(m_out_atom));
                check_field("error_code", want.error_code, 64'(m_error_code));
            end
        end
    end

    // watchdog on cycles without any transfer
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
                (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // test sequence
    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_radices();
        test_range_errors();
        test_radix_limits();
        test_random_traffic(14, 69);
        test_random_traffic(69, 14);
        test_random_traffic(0, 0);
        s_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+design
design/mrci_pkg.sv
design/mrci_entry.sv
design/mrci_div_stage.sv
design/mrci_result.sv
design/mixed_radix_cell_index.sv
test/tb_top.sv
